// File: rtl/omld_pkg.sv
// Shared types and constants of the outlier marking and 5x5 label dilation block.
// Used by omld_win and by the top level; depends on nothing else.
`default_nettype none

package omld_pkg;

  localparam int LabelW  = 16;
  localparam int ValW    = 32;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 3;
  localparam int FwW     = 12;
  localparam int FhW     = 13;
  localparam int Taps    = 5;
  localparam int SelW    = 3;
  localparam int LbRows  = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAutoLow      = 3'd0,
    CfgAutoHigh     = 3'd1,
    CfgManualLow    = 3'd2,
    CfgManualHigh   = 3'd3,
    CfgManualEnable = 3'd4,
    CfgOutlierLabel = 3'd5,
    CfgFrameWidth   = 3'd6,
    CfgFrameHeight  = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    OpPixel = 1'b0,
    OpFlush = 1'b1
  } op_e;

  typedef struct packed {
    logic                     opcode;
    logic signed [ValW-1:0]   pixel_value;
    logic        [LabelW-1:0] seg_label;
  } in_word_t;

  typedef struct packed {
    logic [LabelW-1:0] out_label;
    logic              frame_last;
  } out_word_t;

  // One column of the window: element 4 is the newest row, element 0 the oldest.
  typedef logic [Taps-1:0][LabelW-1:0] col_vec_t;

  // One line buffer entry: slot 0 holds the row just above the current one.
  typedef logic [LbRows-1:0][LabelW-1:0] lb_vec_t;

  // Window taps picked for each column offset (age) and row offset (elem).
  typedef struct packed {
    logic [Taps-1:0][SelW-1:0] age;
    logic [Taps-1:0][SelW-1:0] elem;
  } sel_t;

endpackage

`default_nettype wire

// File: rtl/omld_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module omld_ram #(
  parameter int Width = 64,
  parameter int Depth = 2048,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/omld_win.sv
// 5x5 label window: five column registers and the clamped last-nonzero pick.
// Depends on omld_pkg.
`default_nettype none

module omld_win import omld_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  col_vec_t          col_i,
  input  sel_t              sel_i,
  output logic [LabelW-1:0] label_o
);

  col_vec_t          win_q [Taps];
  logic [LabelW-1:0] col_pick [Taps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < Taps; t++) begin
        win_q[t] <= '0;
      end
    end else if (shift_i) begin
      win_q[0] <= col_i;
      for (int t = 1; t < Taps; t++) begin
        win_q[t] <= win_q[t-1];
      end
    end
  end

  // Last nonzero label, column offset outer and row offset inner.
  always_comb begin
    for (int k = 0; k < Taps; k++) begin
      col_pick[k] = '0;
      for (int r = 0; r < Taps; r++) begin
        if (sel_i.age[k] < SelW'(Taps) && sel_i.elem[r] < SelW'(Taps) &&
            win_q[sel_i.age[k]][sel_i.elem[r]] != '0) begin
          col_pick[k] = win_q[sel_i.age[k]][sel_i.elem[r]];
        end
      end
    end
    label_o = '0;
    for (int k = 0; k < Taps; k++) begin
      if (col_pick[k] != '0) begin
        label_o = col_pick[k];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/outlier_mask_label_dilation.sv
// Outlier marking and 5x5 label dilation. Results pass the stage 1 and stage 2 registers
// and the output queue. Throughput: one word per cycle while the output queue has room,
// set by the line buffer RAM, which takes one read and one write-back every cycle.
// Frames with H*W < 2W+2 pause input after their last pixel until the first window is
// complete. Reset clears control state, configuration and window, not the line buffer RAM.
`default_nettype none

module outlier_mask_label_dilation import omld_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // Column counters address the line buffer; WdW holds the width itself. Rows run a few
  // past the frame height while the last rows drain.
  localparam int ColW      = $clog2(MAX_WIDTH);
  localparam int WdW       = $clog2(MAX_WIDTH + 1);
  localparam int XW        = WdW + 1;
  localparam int RowW      = $clog2(MAX_HEIGHT + 5);
  localparam int YW        = RowW + 1;
  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;
  localparam int CntW      = 3;

  // ---------------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------------
  logic signed [ValW-1:0]   cfg_auto_low_q, cfg_auto_high_q;
  logic signed [ValW-1:0]   cfg_man_low_q, cfg_man_high_q;
  logic                     cfg_man_en_q;
  logic        [LabelW-1:0] cfg_olab_q;
  logic        [FwW-1:0]    cfg_fw_q;
  logic        [FhW-1:0]    cfg_fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_auto_low_q  <= 32'sh8000_0000;
      cfg_auto_high_q <= 32'sh7FFF_FFFF;
      cfg_man_low_q   <= '0;
      cfg_man_high_q  <= '0;
      cfg_man_en_q    <= 1'b0;
      cfg_olab_q      <= LabelW'(1);
      cfg_fw_q        <= FwW'(2048);
      cfg_fh_q        <= FhW'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgAutoLow:      cfg_auto_low_q  <= cfg_data_i;
        CfgAutoHigh:     cfg_auto_high_q <= cfg_data_i;
        CfgManualLow:    cfg_man_low_q   <= cfg_data_i;
        CfgManualHigh:   cfg_man_high_q  <= cfg_data_i;
        CfgManualEnable: cfg_man_en_q    <= cfg_data_i[0];
        CfgOutlierLabel: cfg_olab_q      <= cfg_data_i[LabelW-1:0];
        CfgFrameWidth:   cfg_fw_q        <= cfg_data_i[FwW-1:0];
        CfgFrameHeight:  cfg_fh_q        <= cfg_data_i[FhW-1:0];
        default: ;
      endcase
    end
  end

  // Geometry in use: zero reads as one, values above the maximum saturate.
  logic [WdW-1:0]  w_eff;
  logic [ColW-1:0] w_m1;
  logic [RowW-1:0] h_eff, h_m1;

  always_comb begin
    if (cfg_fw_q == '0) begin
      w_eff = WdW'(1);
    end else if (32'(cfg_fw_q) > 32'(MAX_WIDTH)) begin
      w_eff = WdW'(MAX_WIDTH);
    end else begin
      w_eff = WdW'(cfg_fw_q);
    end
    if (cfg_fh_q == '0) begin
      h_eff = RowW'(1);
    end else if (32'(cfg_fh_q) > 32'(MAX_HEIGHT)) begin
      h_eff = RowW'(MAX_HEIGHT);
    end else begin
      h_eff = RowW'(cfg_fh_q);
    end
  end

  assign w_m1 = ColW'(w_eff - WdW'(1));
  assign h_m1 = h_eff - RowW'(1);

  // ---------------------------------------------------------------------------------
  // Scan position. The input counters keep running past the last input row while the
  // final rows drain, so that every result sees its window exactly 2W+2 positions
  // behind the newest column written into the line buffer.
  // ---------------------------------------------------------------------------------
  logic [ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;

  logic [ColW-1:0] col_c, pos_i;
  logic [RowW-1:0] pos_j;
  logic            in_done, started, catchup, is_pix;
  logic            acc, acts, emit, step, emit_last;
  logic [WdW-1:0]  in_col_inc, out_col_inc;
  logic            out_wrap;
  logic [RowW-1:0] out_row_inc;

  logic [CntW-1:0] fifo_cnt_q, fifo_cnt_d, reserved;
  logic            s1_step_q, s1_emit_q, s1_last_q, s1_fwd_q;
  logic            s2_emit_q, s2_last_q;

  assign in_done = in_row_q >= h_eff;
  assign col_c   = (WdW'(in_col_q) < w_eff) ? in_col_q : w_m1;
  assign is_pix  = (op_e'(in_data_i.opcode) == OpPixel);

  // The current scan position lies at least 2W+2 pixels into the frame.
  assign started = (in_row_q > RowW'(3)) ||
                   (in_row_q == RowW'(3) && w_eff >= WdW'(2)) ||
                   (in_row_q == RowW'(2) && col_c >= ColW'(2));

  // Tiny frames end before the first result is due; the block then steps the scan
  // position on its own, with input held off, until the first window is complete.
  assign catchup = in_done && !started;

  // Space in the output queue is reserved for every result still in the pipeline.
  assign reserved   = fifo_cnt_q + CntW'(s1_emit_q) + CntW'(s2_emit_q);
  assign in_ready_o = !catchup && (reserved < CntW'(FifoDepth));
  assign acc        = in_valid_i && in_ready_o;

  // A flush word before the frame is complete does nothing at all. A pixel word after
  // the last input pixel counts as a flush.
  assign acts = acc && (in_done || is_pix);
  assign emit = acts && started;
  assign step = acts || catchup;

  assign in_col_inc  = WdW'(in_col_q) + WdW'(1);
  assign out_col_inc = WdW'(out_col_q) + WdW'(1);
  assign out_wrap    = out_col_inc >= w_eff;
  assign out_row_inc = out_row_q + RowW'(out_wrap);
  assign emit_last   = out_row_inc >= h_eff;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (step) begin
      if (in_col_inc >= w_eff) begin
        in_col_d = '0;
        in_row_d = in_row_q + RowW'(1);
      end else begin
        in_col_d = ColW'(in_col_inc);
      end
    end
    if (emit) begin
      out_col_d = out_wrap ? '0 : ColW'(out_col_inc);
      out_row_d = out_row_inc;
      if (emit_last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // ---------------------------------------------------------------------------------
  // Window tap selection for the result: border replication turns into a choice of
  // column age and row element within the 5x5 window.
  // ---------------------------------------------------------------------------------
  sel_t sel_d;

  assign pos_i = (WdW'(out_col_q) < w_eff) ? out_col_q : w_m1;
  assign pos_j = (out_row_q < h_eff) ? out_row_q : h_m1;

  always_comb begin
    for (int k = 0; k < Taps; k++) begin
      if (k < 2 && XW'(pos_i) < XW'(2 - k)) begin
        sel_d.age[k] = SelW'(XW'(pos_i) + XW'(2));
      end else if (XW'(pos_i) + XW'(k) > XW'(w_m1) + XW'(2)) begin
        sel_d.age[k] = SelW'(XW'(pos_i) + XW'(2) - XW'(w_m1));
      end else begin
        sel_d.age[k] = SelW'(4 - k);
      end
      if (k < 2 && YW'(pos_j) < YW'(2 - k)) begin
        sel_d.elem[k] = SelW'(YW'(2) - YW'(pos_j));
      end else if (YW'(pos_j) + YW'(k) > YW'(h_m1) + YW'(2)) begin
        sel_d.elem[k] = SelW'(YW'(h_m1) + YW'(2) - YW'(pos_j));
      end else begin
        sel_d.elem[k] = SelW'(k);
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Outlier marking of the incoming pixel.
  // ---------------------------------------------------------------------------------
  logic              outlier;
  logic [LabelW-1:0] new_lab;

  always_comb begin
    outlier = (in_data_i.pixel_value < cfg_auto_low_q) ||
              (cfg_auto_high_q < in_data_i.pixel_value);
    if (cfg_man_en_q && ((in_data_i.pixel_value < cfg_man_low_q) ||
                         (cfg_man_high_q < in_data_i.pixel_value))) begin
      outlier = 1'b1;
    end
    new_lab = in_data_i.seg_label;
    if (in_data_i.seg_label == '0 && outlier) begin
      new_lab = cfg_olab_q;
    end
  end

  // ---------------------------------------------------------------------------------
  // Stage 1: the line buffer entry of this column arrives from the RAM, the new label
  // is pushed into it and the entry is written back. Back-to-back visits of the same
  // column (frames one pixel wide) take the entry from the forwarding register.
  // ---------------------------------------------------------------------------------
  logic [ColW-1:0]   s1_addr_q;
  logic [LabelW-1:0] s1_lab_q;
  sel_t              s1_sel_q, s2_sel_q;
  lb_vec_t           fwd_vec_q, lb_rd, lb_old, lb_new;
  col_vec_t          col_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_step_q <= 1'b0;
      s1_emit_q <= 1'b0;
      s1_fwd_q  <= 1'b0;
      s2_emit_q <= 1'b0;
    end else begin
      s1_step_q <= step;
      s1_emit_q <= emit;
      s1_fwd_q  <= s1_step_q && step && (col_c == s1_addr_q);
      s2_emit_q <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_addr_q <= col_c;
      // Drained rows below the frame are never selected; their label is zero.
      s1_lab_q  <= (acts && is_pix && !in_done) ? new_lab : '0;
      s1_sel_q  <= sel_d;
      s1_last_q <= emit_last;
    end
    fwd_vec_q <= lb_new;
    s2_sel_q  <= s1_sel_q;
    s2_last_q <= s1_last_q;
  end

  omld_ram #(
    .Width($bits(lb_vec_t)),
    .Depth(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_step_q),
    .waddr_i(s1_addr_q),
    .wdata_i(lb_new),
    .re_i   (step),
    .raddr_i(col_c),
    .rdata_o(lb_rd)
  );

  assign lb_old = s1_fwd_q ? fwd_vec_q : lb_rd;
  assign lb_new = {lb_old[2], lb_old[1], lb_old[0], s1_lab_q};
  assign col_vec = {s1_lab_q, lb_old[0], lb_old[1], lb_old[2], lb_old[3]};

  // ---------------------------------------------------------------------------------
  // Stage 2: window pick, then into the output queue.
  // ---------------------------------------------------------------------------------
  logic [LabelW-1:0] win_label;

  omld_win u_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(s1_step_q),
    .col_i  (col_vec),
    .sel_i  (s2_sel_q),
    .label_o(win_label)
  );

  out_word_t         fifo_q [FifoDepth];
  logic [FifoAw-1:0] fifo_wr_q, fifo_rd_q;
  logic              push, pop;

  assign push = s2_emit_q;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    fifo_cnt_d = fifo_cnt_q;
    if (push && !pop) begin
      fifo_cnt_d = fifo_cnt_q + CntW'(1);
    end else if (pop && !push) begin
      fifo_cnt_d = fifo_cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_cnt_q <= '0;
      fifo_wr_q  <= '0;
      fifo_rd_q  <= '0;
    end else begin
      fifo_cnt_q <= fifo_cnt_d;
      if (push) begin
        fifo_wr_q <= fifo_wr_q + FifoAw'(1);
      end
      if (pop) begin
        fifo_rd_q <= fifo_rd_q + FifoAw'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[fifo_wr_q] <= '{out_label: win_label, frame_last: s2_last_q};
    end
  end

  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_data_o  = fifo_q[fifo_rd_q];

  // ---------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------
  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> fifo_cnt_q < CntW'(FifoDepth))
    else $error("output queue overflow");

  a_reserve_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reserved <= CntW'(FifoDepth))
    else $error("more results in flight than queue space");

  a_fwd_consecutive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> s1_step_q && $past(s1_step_q))
    else $error("line buffer forwarding without a preceding write-back");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && emit_last |=> in_col_q == '0 && in_row_q == '0 && out_row_q == '0)
    else $error("scan position not restarted after the final pixel");

endmodule

`default_nettype wire
